// ===== sv/cebb_pkg.sv =====
// shared types and constants of the coverage edge background blend
package cebb_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_BLEND_WEIGHT = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int SIZE_W     = 11;
	localparam int WEIGHT_W   = 9;
	localparam int COORD_W    = 10;
	localparam int CHAN_W     = 8;

	// depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// emit mask bits of a job
	localparam int EMIT_DIAG  = 0;	// pixel up and left of the current one
	localparam int EMIT_ABOVE = 1;	// pixel above, at the row end
	localparam int EMIT_SELF  = 2;	// current pixel, in the last row

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		rgb_t fg;
		rgb_t bg;
	} color_t;

	// work handed from the front to the back for one accepted pixel
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [2:0]         emit;
		logic               blend;
		color_t             held;
		color_t             old;
		color_t             cur;
	} job_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

endpackage

// ===== sv/cebb_queue.sv =====
// job queue between the classifying front and the emitting back
module cebb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cebb_pkg::job_t     push_job,
	input  logic               pop,
	output cebb_pkg::job_t     head,
	output cebb_pkg::q_status_t stat
);
	import cebb_pkg::*;

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	assign head          = slot_q[rd_ptr_q];
	assign stat.full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign stat.nonempty = (count_q != '0);

endmodule

// ===== sv/cebb_front.sv =====
// front: pixel intake, position counters, line buffers and edge classification
module cebb_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cebb_pkg::SIZE_W-1:0]   frame_width,
	input  logic [cebb_pkg::SIZE_W-1:0]   frame_height,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          frame_start,
	input  logic                          covered,
	input  cebb_pkg::color_t              pixel,
	output logic                          q_push,
	output cebb_pkg::job_t                q_job,
	input  cebb_pkg::q_status_t           q_stat
);
	import cebb_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [WW-1:0] w_c, w_m1;
	logic [HW-1:0] h_c, h_m1;
	logic [AW-1:0] col_q, x0;
	logic [YW-1:0] row_q, y0;
	logic          last_col0, last_row0;
	logic          acc, go;

	logic          s1_valid_q;
	logic [AW-1:0] x_s1;
	logic [YW-1:0] y_s1;
	logic          last_col_s1, last_row_s1, cov_s1;
	color_t        cur_s1;
	logic          fwd_s1;
	logic [1:0]    cov_fw_s1, cov_rd_s1;
	color_t        color_fw_s1, color_rd_s1;

	logic [8:0]    window_q;
	color_t        held_q;

	logic [1:0]    cov_mem [MAX_WIDTH];
	color_t        color_mem [MAX_WIDTH];

	logic [1:0]    cov_eff, cov_wr;
	color_t        color_eff;
	logic [2:0]    col_bits;
	logic [8:0]    window_next;
	logic          interior, center, open_nb;

	// clamp sizes to the supported range
	always_comb begin
		if (frame_width < SIZE_W'(3)) begin
			w_c = WW'(3);
		end else if (32'(frame_width) > MAX_WIDTH) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(frame_width);
		end
		if (frame_height < SIZE_W'(3)) begin
			h_c = HW'(3);
		end else if (32'(frame_height) > MAX_HEIGHT) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(frame_height);
		end
	end

	assign w_m1 = w_c - WW'(1);
	assign h_m1 = h_c - HW'(1);

	// position of the incoming pixel
	always_comb begin
		if (frame_start) begin
			x0 = '0;
			y0 = '0;
		end else begin
			x0 = (WW'(col_q) < w_c) ? col_q : AW'(w_m1);
			y0 = (HW'(row_q) < h_c) ? row_q : YW'(h_m1);
		end
	end

	assign last_col0 = (WW'(x0) == w_m1);
	assign last_row0 = (HW'(y0) == h_m1);

	assign in_stall = s1_valid_q && q_stat.full;
	assign acc      = in_valid && !in_stall;
	assign go       = s1_valid_q && !q_stat.full;

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_col0) begin
				col_q <= '0;
				row_q <= last_row0 ? '0 : y0 + YW'(1);
			end else begin
				col_q <= x0 + AW'(1);
				row_q <= y0;
			end
		end
	end

	// line buffers: bit0 of coverage is row y-1, bit1 is row y-2
	always_ff @(posedge clk) begin
		if (acc) begin
			cov_rd_s1   <= cov_mem[x0];
			color_rd_s1 <= color_mem[x0];
		end
		if (go) begin
			cov_mem[x_s1]   <= cov_wr;
			color_mem[x_s1] <= cur_s1;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid_q <= 1'b1;
				fwd_s1     <= s1_valid_q && (x_s1 == x0);
			end else if (go) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// stage 1 payload, with bypass of the entry written in the same cycle
	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1        <= x0;
			y_s1        <= y0;
			last_col_s1 <= last_col0;
			last_row_s1 <= last_row0;
			cov_s1      <= covered;
			cur_s1      <= pixel;
			cov_fw_s1   <= cov_wr;
			color_fw_s1 <= cur_s1;
		end
	end

	assign cov_eff   = fwd_s1 ? cov_fw_s1 : cov_rd_s1;
	assign color_eff = fwd_s1 ? color_fw_s1 : color_rd_s1;
	assign cov_wr    = {cov_eff[0], cov_s1};

	// 3x3 coverage window, newest column in the low bits
	assign col_bits    = {cov_s1, cov_eff[0], cov_eff[1]};
	assign window_next = {window_q[5:0], col_bits};

	assign interior = (x_s1 > AW'(1)) && (y_s1 > YW'(1));
	assign center   = window_next[4];
	assign open_nb  = ((~window_next) & 9'h1EF) != 9'h000;

	// window and held color advance as the pixel leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			held_q   <= '0;
		end else if (go) begin
			window_q <= window_next;
			held_q   <= color_eff;
		end
	end

	// job for the back end
	always_comb begin
		q_job.x                = COORD_W'(x_s1);
		q_job.y                = COORD_W'(y_s1);
		q_job.emit[EMIT_DIAG]  = (y_s1 != '0) && (x_s1 != '0);
		q_job.emit[EMIT_ABOVE] = (y_s1 != '0) && last_col_s1;
		q_job.emit[EMIT_SELF]  = last_row_s1;
		q_job.blend            = interior && center && open_nb;
		q_job.held             = held_q;
		q_job.old              = color_eff;
		q_job.cur              = cur_s1;
	end

	assign q_push = go && (q_job.emit != 3'b000);

endmodule

// ===== sv/cebb_back.sv =====
// back: walks the results of each job, blends edge pixels, holds the output register
module cebb_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [cebb_pkg::WEIGHT_W-1:0]  blend_weight,
	input  cebb_pkg::job_t                 q_head,
	input  cebb_pkg::q_status_t            q_stat,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [cebb_pkg::COORD_W-1:0]   out_x,
	output logic [cebb_pkg::COORD_W-1:0]   out_y,
	output logic [cebb_pkg::CHAN_W-1:0]    out_r,
	output logic [cebb_pkg::CHAN_W-1:0]    out_g,
	output logic [cebb_pkg::CHAN_W-1:0]    out_b,
	output logic                           last_of_step
);
	import cebb_pkg::*;

	job_t                job_q;
	logic                job_valid_q;
	logic [2:0]          rem_q, rem_next;
	logic                issue, last;
	logic [WEIGHT_W-1:0] wt;
	color_t              src;
	logic                do_blend;
	logic [COORD_W-1:0]  rx, ry;
	rgb_t                res;

	// mix one channel with the background, weight in 1/256 units
	function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] c,
		input logic [CHAN_W-1:0] bg, input logic [WEIGHT_W-1:0] w);
		logic [16:0] a, b, s;
		a = 17'(c) * 17'(WEIGHT_W'(9'd256) - w);
		b = 17'(bg) * 17'(w);
		s = a + b;
		return s[15:8];
	endfunction

	assign wt = (blend_weight > WEIGHT_W'(256)) ? WEIGHT_W'(256) : blend_weight;

	assign issue = job_valid_q && (!out_valid || !out_stall);

	// pick the pending result in emission order
	always_comb begin
		rem_next = rem_q;
		rx       = job_q.x;
		ry       = job_q.y;
		src      = job_q.cur;
		do_blend = 1'b0;
		if (rem_q[EMIT_DIAG]) begin
			rem_next[EMIT_DIAG] = 1'b0;
			rx       = job_q.x - COORD_W'(1);
			ry       = job_q.y - COORD_W'(1);
			src      = job_q.held;
			do_blend = job_q.blend;
		end else if (rem_q[EMIT_ABOVE]) begin
			rem_next[EMIT_ABOVE] = 1'b0;
			ry  = job_q.y - COORD_W'(1);
			src = job_q.old;
		end else begin
			rem_next[EMIT_SELF] = 1'b0;
		end
	end

	assign last  = (rem_next == 3'b000);
	assign q_pop = q_stat.nonempty && (!job_valid_q || (issue && last));

	// blend or pass through
	always_comb begin
		if (do_blend) begin
			res.r = mix(src.fg.r, src.bg.r, wt);
			res.g = mix(src.fg.g, src.bg.g, wt);
			res.b = mix(src.fg.b, src.bg.b, wt);
		end else begin
			res = src.fg;
		end
	end

	// current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			rem_q       <= '0;
		end else begin
			if (q_pop) begin
				job_valid_q <= 1'b1;
				rem_q       <= q_head.emit;
			end else if (issue) begin
				job_valid_q <= !last;
				rem_q       <= rem_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (issue) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			out_x        <= rx;
			out_y        <= ry;
			out_r        <= res.r;
			out_g        <= res.g;
			out_b        <= res.b;
			last_of_step <= last;
		end
	end

endmodule

// ===== sv/coverage_edge_background_blend.sv =====
// top level of the coverage edge background blend: config registers and wiring
//
// Pixels enter in raster order on the in_valid / in_stall channel, one
// transaction per pixel: frame_start, the coverage bit, the rendered color
// and the background color at that place. Each pixel is judged once its
// lower right neighbor has arrived, so results trail the input by one row
// and one column and carry their own out_x / out_y. A covered interior pixel
// with an uncovered neighbor is mixed with its background by blend_weight;
// every other pixel passes unchanged. One input transaction gives zero to
// three results; last_of_step marks the last of them.
// Throughput: one pixel per cycle in ordinary rows while the queue has room;
// the row end gives two results and the first column none. In the last row
// each pixel also emits itself, so the queue fills and the input is stalled
// there; the back end catches up in the next frame's first row, which gives
// no results. Results pass stage 1, the job queue and the job register
// before the output register. Configuration writes (cfg_valid / cfg_ready,
// always ready) are to be made by the user while the block is idle; the
// block does not enforce it. Reset clears counters, window, queue and output
// valid; line buffers need no clearing. A stalled output holds its
// transaction and the queue keeps the front running until it fills.
module coverage_edge_background_blend #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cebb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cebb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             frame_start,
	input  logic                             covered,
	input  logic [7:0]                       pix_r,
	input  logic [7:0]                       pix_g,
	input  logic [7:0]                       pix_b,
	input  logic [7:0]                       bg_r,
	input  logic [7:0]                       bg_g,
	input  logic [7:0]                       bg_b,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [9:0]                       out_x,
	output logic [9:0]                       out_y,
	output logic [7:0]                       out_r,
	output logic [7:0]                       out_g,
	output logic [7:0]                       out_b,
	output logic                             last_of_step
);
	import cebb_pkg::*;

	logic [SIZE_W-1:0]   frame_width_q;
	logic [SIZE_W-1:0]   frame_height_q;
	logic [WEIGHT_W-1:0] blend_weight_q;
	color_t              pixel;
	logic                q_push, q_pop;
	job_t                q_job, q_head;
	q_status_t           q_stat;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= SIZE_W'(800);
			frame_height_q <= SIZE_W'(800);
			blend_weight_q <= WEIGHT_W'(77);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[SIZE_W-1:0];
				end
				CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[SIZE_W-1:0];
				end
				CFG_BLEND_WEIGHT: begin
					blend_weight_q <= cfg_data[WEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign pixel.fg.r = pix_r;
	assign pixel.fg.g = pix_g;
	assign pixel.fg.b = pix_b;
	assign pixel.bg.r = bg_r;
	assign pixel.bg.g = bg_g;
	assign pixel.bg.b = bg_b;

	cebb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_start  (frame_start),
		.covered      (covered),
		.pixel        (pixel),
		.q_push       (q_push),
		.q_job        (q_job),
		.q_stat       (q_stat)
	);

	cebb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	cebb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.blend_weight (blend_weight_q),
		.q_head       (q_head),
		.q_stat       (q_stat),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_r        (out_r),
		.out_g        (out_g),
		.out_b        (out_b),
		.last_of_step (last_of_step)
	);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the coverage edge background blend with its own pixel predictor

typedef struct packed {
	logic             start;
	logic             cov;
	cebb_pkg::color_t color;
} pixel_t;

typedef struct packed {
	logic [9:0]     x;
	logic [9:0]     y;
	cebb_pkg::rgb_t rgb;
	logic           last;
} blended_pixel_t;

// predicts the emitted pixels and holds them until the block delivers them
class edge_blend_scoreboard;
	logic [10:0]      frame_width_reg;
	logic [10:0]      frame_height_reg;
	logic [8:0]       weight_reg;
	bit               cov_above [1024];
	bit               cov_above2 [1024];
	cebb_pkg::color_t color_above [1024];
	bit [9:0]         column_pos;
	bit [9:0]         row_pos;
	bit [8:0]         cov_window;
	cebb_pkg::color_t held_color;
	blended_pixel_t   expected_pixels [$];
	int               failures;

	function new();
		frame_width_reg = 11'd800;
		frame_height_reg = 11'd800;
		weight_reg = 9'd77;
		column_pos = '0;
		row_pos = '0;
		cov_window = '0;
		held_color = '0;
		failures = 0;
	endfunction

	function void write_register(logic [1:0] index, logic [10:0] data);
		case (index)
			cebb_pkg::CFG_FRAME_WIDTH: frame_width_reg = data;
			cebb_pkg::CFG_FRAME_HEIGHT: frame_height_reg = data;
			cebb_pkg::CFG_BLEND_WEIGHT: weight_reg = data[8:0];
			default: ;
		endcase
	endfunction

	// per channel mix of the rendered color with the background
	function cebb_pkg::rgb_t mix_with_background(cebb_pkg::color_t c);
		int unsigned wt;
		cebb_pkg::rgb_t m;
		wt = (weight_reg > 9'd256) ? 256 : int'(weight_reg);
		m.r = 8'((int'(c.fg.r) * (256 - wt) + int'(c.bg.r) * wt) >> 8);
		m.g = 8'((int'(c.fg.g) * (256 - wt) + int'(c.bg.g) * wt) >> 8);
		m.b = 8'((int'(c.fg.b) * (256 - wt) + int'(c.bg.b) * wt) >> 8);
		return m;
	endfunction

	function blended_pixel_t result_at(int unsigned x, int unsigned y, cebb_pkg::rgb_t rgb);
		blended_pixel_t r;
		r.x = 10'(x);
		r.y = 10'(y);
		r.rgb = rgb;
		r.last = 1'b0;
		return r;
	endfunction

	// one accepted pixel transaction: update windows and lines, queue what it releases
	function void note_pixel(pixel_t px);
		int unsigned w, h, x, y;
		bit [2:0] vcol;
		bit edge_hit;
		cebb_pkg::color_t old;
		blended_pixel_t made [3];
		int n;
		n = 0;
		w = (frame_width_reg < 11'd3) ? 3 : (frame_width_reg > 11'd1024) ? 1024 :
			int'(frame_width_reg);
		h = (frame_height_reg < 11'd3) ? 3 : (frame_height_reg > 11'd1024) ? 1024 :
			int'(frame_height_reg);
		if (px.start) begin
			x = 0;
			y = 0;
		end else begin
			// counters beyond a narrowed frame stick to the last column or row
			x = (column_pos < w) ? int'(column_pos) : w - 1;
			y = (row_pos < h) ? int'(row_pos) : h - 1;
		end

		// coverage column: bit 0 two rows up, bit 1 one row up, bit 2 this row
		vcol = {px.cov, cov_above[x], cov_above2[x]};
		cov_above2[x] = cov_above[x];
		cov_above[x] = px.cov;
		cov_window = {cov_window[5:0], vcol};
		old = color_above[x];
		color_above[x] = px.color;

		if (y >= 1) begin
			if (x >= 1) begin
				// covered interior pixel with any uncovered neighbor
				edge_hit = x >= 2 && y >= 2 && cov_window[4] && ((~cov_window & 9'h1EF) != 0);
				made[n] = result_at(x - 1, y - 1,
					edge_hit ? mix_with_background(held_color) : held_color.fg);
				n++;
			end
			if (x == w - 1) begin
				made[n] = result_at(x, y - 1, old.fg);
				n++;
			end
		end
		// last row pixels are border pixels and leave at once
		if (y == h - 1) begin
			made[n] = result_at(x, y, px.color.fg);
			n++;
		end
		held_color = old;
		for (int k = 0; k < n; k++) begin
			if (k == n - 1)
				made[k].last = 1'b1;
			expected_pixels.push_back(made[k]);
		end

		// raster advance with wrap into the next frame
		x++;
		if (x >= w) begin
			x = 0;
			y++;
			if (y >= h)
				y = 0;
		end
		column_pos = 10'(x);
		row_pos = 10'(y);
	endfunction

	function void compare_field(string name, logic [9:0] want, logic [9:0] seen);
		if (seen !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
			failures++;
		end
	endfunction

	// one accepted result transaction against the oldest prediction
	function void check_pixel_out(blended_pixel_t got);
		blended_pixel_t want;
		if (expected_pixels.size() == 0) begin
			$display("%0t: result expected none actual x %0d y %0d", $time, got.x, got.y);
			failures++;
			return;
		end
		want = expected_pixels.pop_front();
		compare_field("out_x", want.x, got.x);
		compare_field("out_y", want.y, got.y);
		compare_field("out_r", {2'b00, want.rgb.r}, {2'b00, got.rgb.r});
		compare_field("out_g", {2'b00, want.rgb.g}, {2'b00, got.rgb.g});
		compare_field("out_b", {2'b00, want.rgb.b}, {2'b00, got.rgb.b});
		compare_field("last_of_step", {9'd0, want.last}, {9'd0, got.last});
	endfunction
endclass

module testbench;
	import cebb_pkg::*;

	// index with no register behind it
	localparam logic [1:0] CFG_SPARE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        frame_start;
	logic        covered;
	logic [7:0]  pix_r;
	logic [7:0]  pix_g;
	logic [7:0]  pix_b;
	logic [7:0]  bg_r;
	logic [7:0]  bg_g;
	logic [7:0]  bg_b;
	logic        out_valid;
	logic        out_stall;
	logic [9:0]  out_x;
	logic [9:0]  out_y;
	logic [7:0]  out_r;
	logic [7:0]  out_g;
	logic [7:0]  out_b;
	logic        last_of_step;

	edge_blend_scoreboard sb;
	bit sender_idling;
	bit receiver_idling;
	bit long_hold;
	int pixels_sent;

	coverage_edge_background_blend DUT (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// overall time limit
	initial begin
		#3_000_000;
		$display("coverage_edge_background_blend: mismatch");
		$finish;
	end

	// monitor: config writes, accepted pixels and accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_register(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.note_pixel({frame_start, covered, pix_r, pix_g, pix_b, bg_r, bg_g, bg_b});
			if (out_valid && !out_stall)
				sb.check_pixel_out({out_x, out_y, out_r, out_g, out_b, last_of_step});
		end
	end

	// receiver: random stall bursts and one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (80) @(negedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if (receiver_idling && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [7:0] random_channel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic color_t random_color();
		return {random_channel(), random_channel(), random_channel(),
			random_channel(), random_channel(), random_channel()};
	endfunction

	// one pixel transaction, with an optional gap before it
	task automatic send_pixel(input pixel_t px);
		@(negedge clk);
		if (sender_idling && $urandom_range(0, 6) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		{frame_start, covered, pix_r, pix_g, pix_b, bg_r, bg_g, bg_b} <= px;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pixels_sent++;
	endtask

	// run of raster pixels with random content
	task automatic send_pixels(int count, bit with_start, int cov_pct, bit stray_starts);
		pixel_t px;
		for (int i = 0; i < count; i++) begin
			px.start = (i == 0) ? with_start : (stray_starts && $urandom_range(0, 40) == 0);
			px.cov = $urandom_range(0, 99) < cov_pct;
			px.color = random_color();
			send_pixel(px);
		end
	endtask

	// stop sending until every predicted result has come, then let the pipe settle
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic set_register(logic [1:0] index, logic [10:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(int width, int height, int weight);
		drain_results();
		set_register(CFG_FRAME_WIDTH, 11'(width));
		set_register(CFG_FRAME_HEIGHT, 11'(height));
		set_register(CFG_BLEND_WEIGHT, 11'(weight));
	endtask

	initial begin
		pixel_t px;
		int random_goal;
		int w, h, wt, frames, cells, count;
		bit complete, paused_once, with_start, stray;

		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		frame_start = 1'b0;
		covered = 1'b0;
		pix_r = '0;
		pix_g = '0;
		pix_b = '0;
		bg_r = '0;
		bg_g = '0;
		bg_b = '0;
		sender_idling = 1'b1;
		receiver_idling = 1'b1;
		long_hold = 1'b0;
		pixels_sent = 0;
		paused_once = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: smallest frame, center edge pixel at full white over black
		configure(3, 3, 77);
		set_register(CFG_SPARE, 11'($urandom));
		for (int i = 0; i < 9; i++) begin
			px.start = (i == 0);
			px.cov = (i != 0);
			px.color = (i == 4) ? {24'hFFFFFF, 24'h000000} : random_color();
			send_pixel(px);
		end
		// center black over white, uncovered lower right neighbor
		for (int i = 0; i < 9; i++) begin
			px.start = 1'b0;
			px.cov = (i != 8);
			px.color = (i == 4) ? {24'h000000, 24'hFFFFFF} : random_color();
			send_pixel(px);
		end
		// frame abandoned by a new frame start
		send_pixels(2, 1'b1, 50, 1'b0);
		send_pixels(5, 1'b1, 50, 1'b0);

		// sizes below range, zero weight, wrap into the next frame without a start
		configure(0, 1, 0);
		send_pixels(9, 1'b1, 70, 1'b0);
		send_pixels(9, 1'b0, 40, 1'b0);

		// width above range clamped to the widest rows, weight above range: first row
		configure(2047, 3, 511);
		send_pixels(20, 1'b1, 60, 1'b0);

		// receiver holds off while pixels keep coming
		configure(12, 5, 511);
		send_pixels(30, 1'b1, 60, 1'b0);
		long_hold = 1'b1;
		send_pixels(30, 1'b0, 60, 1'b0);

		// tallest frame, full background weight
		configure(3, 2047, 256);
		send_pixels(45, 1'b1, 50, 1'b0);

		// narrowing with the counters beyond the new size
		configure(8, 6, 128);
		send_pixels(39, 1'b1, 50, 1'b0);
		configure(4, 3, 200);
		send_pixels(15, 1'b0, 50, 1'b0);

		// random phases of small frames
		random_goal = pixels_sent + 170;
		while (pixels_sent < random_goal) begin
			w = $urandom_range(3, 9);
			h = $urandom_range(3, 7);
			case ($urandom_range(0, 3))
				0: wt = 77;
				1: wt = $urandom_range(0, 256);
				2: wt = $urandom_range(0, 2047);
				default: wt = $urandom_range(0, 1) ? 256 : 0;
			endcase
			sender_idling = $urandom_range(0, 3) != 0;
			receiver_idling = $urandom_range(0, 3) != 0;
			configure(w, h, wt);
			frames = $urandom_range(1, 3);
			complete = 1'b0;
			for (int f = 0; f < frames; f++) begin
				cells = w * h;
				count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, cells - 1) : cells;
				with_start = !(complete && $urandom_range(0, 4) == 0);
				stray = $urandom_range(0, 7) == 0;
				if (!paused_once && count > 4) begin
					// sender waits mid-frame for every result
					send_pixels(count / 2, with_start, $urandom_range(0, 100), stray);
					drain_results();
					send_pixels(count - count / 2, 1'b0, $urandom_range(0, 100), stray);
					paused_once = 1'b1;
				end else begin
					send_pixels(count, with_start, $urandom_range(0, 100), stray);
				end
				complete = (count == cells) && !stray;
			end
		end

		// closing part at full rate on both sides
		sender_idling = 1'b0;
		receiver_idling = 1'b0;
		w = $urandom_range(3, 9);
		h = $urandom_range(3, 7);
		configure(w, h, $urandom_range(0, 256));
		send_pixels(w * h, 1'b1, 60, 1'b0);
		send_pixels(w * h, 1'b1, 60, 1'b0);

		drain_results();
		if (sb.failures == 0 && sb.expected_pixels.size() == 0)
			$display("coverage_edge_background_blend: match");
		else
			$display("coverage_edge_background_blend: mismatch");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/cebb_pkg.sv
sv/cebb_queue.sv
sv/cebb_front.sv
sv/cebb_back.sv
sv/coverage_edge_background_blend.sv
bench/testbench.sv
